// ===== design/cfd_pkg.sv =====
package cfd_pkg;

   // Code byte that opens a full block with no implied zero after it
   localparam logic [7:0] COBS_MAX_CODE = 8'hff;
   localparam logic [7:0] DELIMITER     = 8'h00;

   // One decoded result
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       frame_end;
      logic       frame_error;
   } result_type;

   // Handshake between decode and the result register
   typedef struct packed {
      logic       load;
      logic       free;
   } out_ctl_type;

endpackage

// ===== design/cobs_frame_decoder_core.sv =====
// COBS frame decoder: takes raw bytes from a serial receiver and gives
// decoded data bytes and frame delimiters.
// Request channel: req_valid / req_stall carry one raw byte, req_in_byte.
// Response channel: rsp_valid / rsp_stall carry one result: a data byte
// (rsp_byte_valid), or a frame end (rsp_frame_end) with rsp_frame_error
// set when the delimiter came inside a block.
// Hunted bytes, code bytes that release no held zero and the implied zero
// at the end of a frame give no response.
// Path: a byte is captured in the input register, decoded combinationally
// and its response is loaded into the response register.
// Throughput: one byte per cycle unless a stall holds it; the per-byte
// decode is a counter update between an input and a response register.
// Reset: the decoder drops all bytes until the first zero byte, then
// decodes frames. Both registers empty.
// Stall: a stalled response holds. The input register still takes one more
// byte, and a byte that gives no response keeps moving; req_stall rises
// once a byte waiting in the input register needs the held response slot.
module cobs_frame_decoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_frame_end,
   output logic       rsp_frame_error
);
   import cfd_pkg::*;

   logic        item_valid;
   logic [7:0]  item_byte;
   logic        consume;
   logic        out_free;
   out_ctl_type ctl;
   result_type  result;
   result_type  rsp_data;

   cfd_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .req_stall   (req_stall),
      .consume     (consume),
      .item_valid  (item_valid),
      .item_byte   (item_byte)
   );

   cfd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_byte  (item_byte),
      .out_free   (out_free),
      .consume    (consume),
      .ctl        (ctl),
      .result     (result)
   );

   cfd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .result    (result),
      .rsp_stall (rsp_stall),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_byte    = rsp_data.out_byte;
   assign rsp_byte_valid  = rsp_data.byte_valid;
   assign rsp_frame_end   = rsp_data.frame_end;
   assign rsp_frame_error = rsp_data.frame_error;

endmodule

// ===== design/cfd_in_reg.sv =====
module cfd_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_in_byte,
   output logic       req_stall,
   input  logic       consume,
   output logic       item_valid,
   output logic [7:0] item_byte
);
   import cfd_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       take;

   // Hold the request while decode cannot consume it
   assign req_stall  = valid_ff && !consume;
   assign take       = req_valid && !req_stall;
   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture the request byte
   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_in_byte;
      end
   end

endmodule

// ===== design/cfd_decode.sv =====
module cfd_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  logic [7:0]          item_byte,
   input  logic                out_free,
   output logic                consume,
   output cfd_pkg::out_ctl_type ctl,
   output cfd_pkg::result_type result
);
   import cfd_pkg::*;

   logic       in_sync_ff;
   logic       in_sync_in;
   logic [7:0] bytes_left_ff;
   logic [7:0] bytes_left_in;
   logic       zero_pending_ff;
   logic       zero_pending_in;
   logic       has_result;
   logic       is_delim;
   logic       in_block;

   assign is_delim = (item_byte == DELIMITER);
   assign in_block = (bytes_left_ff != 8'd0);

   // Classify the byte and form the result and next state
   always_comb begin
      has_result         = 1'b0;
      result             = '0;
      in_sync_in         = in_sync_ff;
      bytes_left_in      = bytes_left_ff;
      zero_pending_in    = zero_pending_ff;
      if (!in_sync_ff) begin
         // hunt for the first delimiter
         if (is_delim) begin
            in_sync_in      = 1'b1;
            bytes_left_in   = 8'd0;
            zero_pending_in = 1'b0;
         end
      end else if (is_delim) begin
         // close the frame, drop the trailing implied zero
         has_result         = 1'b1;
         result.frame_end   = 1'b1;
         result.frame_error = in_block;
         bytes_left_in      = 8'd0;
         zero_pending_in    = 1'b0;
      end else if (in_block) begin
         // pass a data byte
         has_result        = 1'b1;
         result.out_byte   = item_byte;
         result.byte_valid = 1'b1;
         bytes_left_in     = bytes_left_ff - 8'd1;
      end else begin
         // code byte: release the held zero, open the next block
         has_result        = zero_pending_ff;
         result.byte_valid = zero_pending_ff;
         bytes_left_in     = item_byte - 8'd1;
         zero_pending_in   = (item_byte != COBS_MAX_CODE);
      end
   end

   // Advance when the result register has room or nothing is produced
   assign consume  = item_valid && (!has_result || out_free);
   assign ctl.load = consume && has_result;
   assign ctl.free = out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sync_ff      <= 1'b0;
         bytes_left_ff   <= 8'd0;
         zero_pending_ff <= 1'b0;
      end else if (consume) begin
         in_sync_ff      <= in_sync_in;
         bytes_left_ff   <= bytes_left_in;
         zero_pending_ff <= zero_pending_in;
      end
   end

endmodule

// ===== design/cfd_out_reg.sv =====
module cfd_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  cfd_pkg::out_ctl_type ctl,
   input  cfd_pkg::result_type  result,
   input  logic                 rsp_stall,
   output logic                 out_free,
   output logic                 rsp_valid,
   output cfd_pkg::result_type  rsp_data
);
   import cfd_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   // Free when empty or the held result leaves this cycle
   assign out_free  = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.load) begin
         valid_in = 1'b1;
      end else if (ctl.free) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load a new result
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         data_ff <= result;
      end
   end

endmodule

// ===== design/cfd_checker.sv =====
module cfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_frame_end,
   input logic       rsp_frame_error
);

   // No response right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_byte_valid) && $stable(rsp_frame_end)
         && $stable(rsp_frame_error))
      else $error("stalled response changed");

   // A response is either a data byte or a frame end
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_valid != rsp_frame_end))
      else $error("response is neither or both kinds");

   // On a response that is not a data byte, an error flag comes only with a frame end, and the byte is zero
   a_error_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_out_byte == 8'd0
         && (rsp_frame_end || !rsp_frame_error))
      else $error("frame end response malformed");

   // Right after reset, no response comes without a request
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !req_valid |=> !rsp_valid)
      else $error("response without a request");

endmodule

bind cobs_frame_decoder_core cfd_checker u_cfd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_byte_valid  (rsp_byte_valid),
   .rsp_frame_end   (rsp_frame_end),
   .rsp_frame_error (rsp_frame_error)
);

// ===== tb/cobs_decode_check_pkg.sv =====
package cobs_decode_check_pkg;
   import cfd_pkg::*;

   class cobs_decode_checker;
      // Decoder state rebuilt from the accepted request stream
      bit         synced;
      logic [7:0] left_in_block;
      bit         zero_held;
      result_type decoded_q[$];
      int         mismatches;

      function new();
         synced        = 1'b0;
         left_in_block = 8'h00;
         zero_held     = 1'b0;
         mismatches    = 0;
      endfunction

      // Decode one accepted byte and queue the response it should give
      function void note_request(logic [7:0] raw);
         result_type r;
         // Hunt: drop everything up to the first delimiter
         if (!synced) begin
            if (raw == DELIMITER) begin
               synced        = 1'b1;
               left_in_block = 8'h00;
               zero_held     = 1'b0;
            end
            return;
         end
         if (raw == DELIMITER) begin
            // Close the frame; flag it when a block was still open
            r = '{out_byte: 8'h00, byte_valid: 1'b0, frame_end: 1'b1,
                  frame_error: (left_in_block != 8'h00)};
            decoded_q.push_back(r);
            left_in_block = 8'h00;
            zero_held     = 1'b0;
         end else if (left_in_block != 8'h00) begin
            // Pass a data byte through and count down the block
            r = '{out_byte: raw, byte_valid: 1'b1, frame_end: 1'b0, frame_error: 1'b0};
            decoded_q.push_back(r);
            left_in_block = left_in_block - 8'h01;
         end else begin
            // Code byte: release the held zero, open the next block
            if (zero_held) begin
               r = '{out_byte: 8'h00, byte_valid: 1'b1, frame_end: 1'b0,
                     frame_error: 1'b0};
               decoded_q.push_back(r);
            end
            left_in_block = raw - 8'h01;
            zero_held     = (raw != COBS_MAX_CODE);
         end
      endfunction

      // Compare one accepted response with the oldest decoded result
      function void check_response(result_type got);
         result_type want;
         if (decoded_q.size() == 0) begin
            $error("response with nothing outstanding: out_byte %02h byte_valid %0b %s %0b %s %0b",
                   got.out_byte, got.byte_valid, "frame_end", got.frame_end,
                   "frame_error", got.frame_error);
            mismatches++;
            return;
         end
         want = decoded_q.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
            mismatches++;
         end
         if (got.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
            mismatches++;
         end
         if (got.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
            mismatches++;
         end
         if (got.frame_error !== want.frame_error) begin
            $error("frame_error: expected %0b, got %0b", want.frame_error, got.frame_error);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return decoded_q.size();
      endfunction
   endclass

endpackage

// ===== tb/tb_cobs_frame_decoder_core.sv =====
module tb_cobs_frame_decoder_core;
   timeunit 1ns;
   timeprecision 1ps;

   import cfd_pkg::*;
   import cobs_decode_check_pkg::*;

   localparam int TOTAL_BYTES = 1400;
   localparam int IDLE_LIMIT  = 1000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_frame_end;
   logic       rsp_frame_error;

   cobs_decode_checker sb;
   int                 sent = 0;
   bit                 calm = 1'b0;
   logic [7:0]         opening [0:20];

   cobs_frame_decoder_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_frame_error (rsp_frame_error)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one byte, optionally after a short gap, and hold it until taken
   task automatic send_byte(input logic [7:0] raw);
      int gap;
      calm = (sent >= 500) && (sent < 800);
      if (!calm && $urandom_range(0, 99) < 5) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= raw;
      do @(posedge clock); while (req_stall);
      sb.note_request(raw);
      sent++;
   endtask

   // Mostly short blocks, now and then long or full ones
   function automatic logic [7:0] pick_code();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3)
         return COBS_MAX_CODE;
      if (r < 10)
         return 8'($urandom_range(13, 254));
      return 8'($urandom_range(1, 12));
   endfunction

   // Send an encoded frame; a broken one is cut short inside its last block if that block holds data
   task automatic send_frame(input bit broken);
      int         blocks;
      int         k;
      int         i;
      int         n;
      logic [7:0] code;
      blocks = $urandom_range(1, 4);
      for (k = 0; k < blocks; k++) begin
         code = pick_code();
         send_byte(code);
         n = code - 1;
         if (broken && k == blocks - 1 && n > 0)
            n = $urandom_range(0, n - 1);
         for (i = 0; i < n; i++)
            send_byte(8'($urandom_range(1, 255)));
      end
      send_byte(DELIMITER);
   endtask

   // Send raw junk with plenty of delimiters mixed in
   task automatic send_noise();
      int n;
      int i;
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 3) == 0)
            send_byte(DELIMITER);
         else
            send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // Check responses and drive the response-side stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response({rsp_out_byte, rsp_byte_valid, rsp_frame_end, rsp_frame_error});
      rsp_stall <= !calm && ($urandom_range(0, 99) < 9);
   end

   // Stop the run when nothing moves on either channel for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("tb_cobs_frame_decoder_core: FAIL");
      $finish;
   end

   initial begin : stimulus
      int r;
      int j;
      sb = new();
      // Hunt bytes, sync, empty frame, held and dropped zeros,
      // full-block code cut off, data extremes, error delimiter
      opening = '{8'h7e, 8'hff, 8'h01, DELIMITER,
                  DELIMITER,
                  8'h01, 8'h01, DELIMITER,
                  8'h03, 8'hff, 8'h01, DELIMITER,
                  COBS_MAX_CODE, DELIMITER,
                  8'h02, 8'h80, 8'h01, DELIMITER,
                  8'h04, 8'h11, DELIMITER};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (j = 0; j <= 20; j++)
         send_byte(opening[j]);

      // Mostly well-formed frames, some truncated ones and noise
      while (sent < TOTAL_BYTES) begin
         r = $urandom_range(0, 99);
         if (r < 75)
            send_frame(1'b0);
         else if (r < 87)
            send_frame(1'b1);
         else
            send_noise();
      end
      req_valid <= 1'b0;

      // Drain the responses, then give stray ones time to show up
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (sb.mismatches == 0 && sb.outstanding() == 0)
         $display("tb_cobs_frame_decoder_core: PASS");
      else
         $display("tb_cobs_frame_decoder_core: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
design/cfd_pkg.sv
design/cfd_in_reg.sv
design/cfd_decode.sv
design/cfd_out_reg.sv
design/cobs_frame_decoder_core.sv
design/cfd_checker.sv
tb/cobs_decode_check_pkg.sv
tb/tb_cobs_frame_decoder_core.sv
